// ===== rtl/core/kps_pkg.sv =====
package kps_pkg;

    localparam int DRIVE_W     = 12;
    localparam int CODE_W      = 5;
    localparam int TICKS_W     = 8;
    localparam int COL_IDX_W   = 4;
    localparam int COLUMNS_DEF = 12;
    localparam int COLUMNS_MAX = 16;

    localparam logic [TICKS_W-1:0] DEBOUNCE_RESET = 8'd20;

    typedef enum logic [2:0] {
        PH_WAIT_RELEASE = 3'd0,
        PH_WAIT_PRESS   = 3'd1,
        PH_DEBOUNCE     = 3'd2,
        PH_SCAN         = 3'd3,
        PH_RELEASE      = 3'd4
    } phase_t;

    typedef struct packed {
        logic [DRIVE_W-1:0] column_drive;
        logic               key_ready;
        logic [CODE_W-1:0]  key_code;
        logic               no_column;
    } result_t;

endpackage

// ===== rtl/core/kps_fsm.sv =====
module kps_fsm #(
    parameter int COLUMNS = kps_pkg::COLUMNS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [kps_pkg::TICKS_W-1:0]  cfg_data,
    input  logic                         accept,
    input  logic                         tick,
    input  logic                         row_one,
    input  logic                         row_two,
    output kps_pkg::result_t             res
);
    import kps_pkg::*;

    localparam logic [COLUMNS_MAX:0] ALL_WIDE =
        (17'd1 << COLUMNS) - 17'd1;
    localparam logic [DRIVE_W-1:0]   ALL_COLS  = ALL_WIDE[DRIVE_W-1:0];
    localparam logic [COL_IDX_W-1:0] LAST_COL  = COL_IDX_W'(COLUMNS - 1);
    localparam logic [CODE_W-1:0]    ROW2_BASE = CODE_W'(COLUMNS);

    logic [TICKS_W-1:0]   debounce_reg;
    phase_t               phase_reg;
    phase_t               phase_next;
    logic [TICKS_W-1:0]   settle_reg;
    logic [TICKS_W-1:0]   settle_next;
    logic [COL_IDX_W-1:0] column_reg;
    logic [COL_IDX_W-1:0] column_next;
    logic                 second_row_reg;
    logic                 second_row_next;
    logic [CODE_W-1:0]    held_code_reg;
    logic [CODE_W-1:0]    held_code_next;
    logic                 held_no_col_reg;
    logic                 held_no_col_next;
    logic                 sense;
    logic                 any_row;
    logic [CODE_W-1:0]    scan_code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
        end
        else if (cfg_write)
        begin
            debounce_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_WAIT_RELEASE;
            settle_reg      <= '0;
            column_reg      <= '0;
            second_row_reg  <= 1'b0;
            held_code_reg   <= '0;
            held_no_col_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            settle_reg      <= settle_next;
            column_reg      <= column_next;
            second_row_reg  <= second_row_next;
            held_code_reg   <= held_code_next;
            held_no_col_reg <= held_no_col_next;
        end
    end

    assign any_row   = row_one | row_two;
    assign sense     = second_row_reg ? row_two : row_one;
    assign scan_code = (second_row_reg ? ROW2_BASE : CODE_W'(0))
                     + CODE_W'(column_reg);

    always_comb
    begin
        phase_next       = phase_reg;
        settle_next      = settle_reg;
        column_next      = column_reg;
        second_row_next  = second_row_reg;
        held_code_next   = held_code_reg;
        held_no_col_next = held_no_col_reg;
        res.key_ready    = 1'b0;
        res.key_code     = '0;
        res.no_column    = 1'b0;

        unique case (phase_reg)
            PH_WAIT_PRESS:
            begin
                if (any_row)
                begin
                    settle_next = debounce_reg;
                    phase_next  = PH_DEBOUNCE;
                end
            end
            PH_DEBOUNCE:
            begin
                if (settle_reg != '0)
                begin
                    if (tick)
                    begin
                        settle_next = settle_reg - TICKS_W'(1);
                    end
                end
                else if (!any_row)
                begin
                    phase_next = PH_WAIT_PRESS;
                end
                else
                begin
                    second_row_next = ~row_one;
                    column_next     = '0;
                    phase_next      = PH_SCAN;
                end
            end
            PH_SCAN:
            begin
                if (sense)
                begin
                    held_code_next   = scan_code;
                    held_no_col_next = 1'b0;
                    phase_next       = PH_RELEASE;
                end
                else if (column_reg >= LAST_COL)
                begin
                    held_code_next   = '0;
                    held_no_col_next = 1'b1;
                    phase_next       = PH_RELEASE;
                end
                else
                begin
                    column_next = column_reg + COL_IDX_W'(1);
                end
            end
            PH_RELEASE:
            begin
                if (!any_row)
                begin
                    res.key_ready = 1'b1;
                    res.key_code  = held_code_reg;
                    res.no_column = held_no_col_reg;
                    phase_next    = PH_WAIT_RELEASE;
                end
            end
            default:
            begin
                phase_next = any_row ? PH_WAIT_RELEASE : PH_WAIT_PRESS;
            end
        endcase

        res.column_drive = (phase_next == PH_SCAN)
                         ? DRIVE_W'(COLUMNS_MAX'(1) << column_next) : ALL_COLS;
    end

    // A report is only made when leaving the release phase.
    a_ready_from_release: assert property (@(posedge clk) disable iff (!rst_n)
        res.key_ready |-> (phase_reg == PH_RELEASE) && (phase_next == PH_WAIT_RELEASE))
        else $error("key report outside the release phase");

    // A missing column always reports with a zero code.
    a_no_column_code: assert property (@(posedge clk) disable iff (!rst_n)
        res.no_column |-> res.key_ready && (res.key_code == '0))
        else $error("no_column without key_ready or with a nonzero code");

    // The scan never runs past the last column.
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SCAN) |-> (column_reg <= LAST_COL))
        else $error("column index beyond the last column");

    // Staying in the scan moves exactly one column on.
    a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (phase_reg == PH_SCAN) && (phase_next == PH_SCAN)
        |=> column_reg == $past(column_reg) + COL_IDX_W'(1))
        else $error("scan did not advance by one column");

endmodule

// ===== rtl/core/kps_out_stage.sv =====
module kps_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    output logic             accept,
    input  kps_pkg::result_t res,
    output logic             result_valid,
    input  logic             result_stall,
    output kps_pkg::result_t result
);
    import kps_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign item_stall   = valid_reg & result_stall;
    assign accept       = item_valid & ~item_stall;
    assign result_valid = valid_reg;
    assign result       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else if (accept)
        begin
            data_reg <= res;
        end
    end

    // A held result is never overwritten while the receiver stalls.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && result_stall |-> !accept)
        else $error("result overwritten while stalled");

    // Every accepted item produces a valid result in the next cycle.
    a_accept_valid: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> valid_reg)
        else $error("accepted item produced no result");

    // The result register changes only on an accepted item.
    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(data_reg))
        else $error("result register changed without a transfer");

endmodule

// ===== rtl/core/matrix_keypad_scanner_unit.sv =====
// Matrix keypad scanner for two rows of keys with press debounce.
// The input channel (item_valid, item_stall) carries one sample per transfer:
// the millisecond tick flag and the two row levels sensed under the column
// drive of the previous result. The output channel (result_valid,
// result_stall) returns exactly one result per sample: the column drive to
// apply next, and key_ready with key_code and no_column when a press and
// release completes.
// Each sample is processed by the combinational phase logic and lands in the
// result register, so a result appears in the cycle after its transfer and a
// new sample is taken in every cycle while the output is drained.
// When the receiver stalls with a result held, item_stall rises and the held
// result stays unchanged until it is taken. The user must write the debounce
// length through cfg_write and cfg_data only while idle; the block does not
// enforce it. Reset clears the result register and returns the scanner to
// waiting for all keys released, with a debounce length of 20 ticks.
module matrix_keypad_scanner_unit #(
    parameter int COLUMNS = kps_pkg::COLUMNS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [kps_pkg::TICKS_W-1:0]  cfg_data,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic                         tick,
    input  logic                         row_one,
    input  logic                         row_two,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [kps_pkg::DRIVE_W-1:0]  column_drive,
    output logic                         key_ready,
    output logic [kps_pkg::CODE_W-1:0]   key_code,
    output logic                         no_column
);
    import kps_pkg::*;

    logic    accept;
    result_t step_res;
    result_t result;

    kps_fsm #(
        .COLUMNS (COLUMNS)
    ) u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .tick      (tick),
        .row_one   (row_one),
        .row_two   (row_two),
        .res       (step_res)
    );

    kps_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .accept       (accept),
        .res          (step_res),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    assign column_drive = result.column_drive;
    assign key_ready    = result.key_ready;
    assign key_code     = result.key_code;
    assign no_column    = result.no_column;

endmodule
